// ===== rtl/wwmc_pkg.sv =====
`timescale 1ns / 1ps
package wwmc_pkg;

  // fixed field widths
  localparam int SYMBOL_W      = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int PATTERN_W     = 64;
  localparam int LEN_W         = 7;
  localparam int MATCH_COUNT_W = 32;

  // parameter defaults
  localparam int MAX_PATTERN_DEFAULT = 64;
  localparam int COUNT_WIDTH_DEFAULT = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BITS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_WILDCARDS  = 2'd2;

endpackage

// ===== rtl/wwmc_sym_if.sv =====
`timescale 1ns / 1ps
interface wwmc_sym_if;
  import wwmc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SYMBOL_W-1:0] symbol;
  logic                last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

// ===== rtl/wwmc_res_if.sv =====
`timescale 1ns / 1ps
interface wwmc_res_if;
  import wwmc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     window_full;
  logic                     window_match;
  logic [MATCH_COUNT_W-1:0] match_count;
  logic                     final_result;

  modport source (output valid, output window_full, output window_match,
                  output match_count, output final_result, input ready);
  modport sink (input valid, input window_full, input window_match,
                input match_count, input final_result, output ready);
endinterface

// ===== rtl/wwmc_cfg_if.sv =====
`timescale 1ns / 1ps
interface wwmc_cfg_if;
  import wwmc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/wildcard_window_match_counter.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Payload                                               | Beat
// sym     | in  | symbol[1:0], last_symbol                              | one text symbol
// res     | out | window_full, window_match, match_count, final_result | one per symbol
// cfg     | in  | index[1:0], data[63:0]                                | one register write
//
// One symbol per cycle while res is not stalled; each result passes stage 1, then the result register.
// Stage 1 shifts the window and registers the masked compare and per-byte wildcard
// counts; stage 2 sums the counts, checks the limit and updates the saturating count.
// rst (synchronous) clears config to its defaults and all window and count state.
// A stalled res holds the whole pipe; sym still takes a beat while stage 1 is empty.
module wildcard_window_match_counter #(
  parameter int MAX_PATTERN = wwmc_pkg::MAX_PATTERN_DEFAULT,
  parameter int COUNT_WIDTH = wwmc_pkg::COUNT_WIDTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  wwmc_sym_if.sink   sym,
  wwmc_res_if.source res,
  wwmc_cfg_if.sink   cfg
);
  import wwmc_pkg::*;

  localparam int FILL_W = $clog2(MAX_PATTERN + 1);
  localparam int NG     = (MAX_PATTERN + 7) / 8;
  localparam int GC_W   = 4;
  localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_PATTERN);
  localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_PATTERN);

  // configuration
  logic [PATTERN_W-1:0] pattern_bits;
  logic [LEN_W-1:0]     pattern_length;
  logic [LEN_W-1:0]     max_wildcards;

  // window state
  logic [MAX_PATTERN-1:0] text_window;
  logic [MAX_PATTERN-1:0] wildcard_mask;
  logic [FILL_W-1:0]      fill_level;
  logic [COUNT_WIDTH-1:0] running_count;

  // stage 1
  logic            s1_valid;
  logic            s1_full;
  logic            s1_last;
  logic            s1_diff_zero;
  logic [GC_W-1:0] s1_group_cnt [NG];

  // result register
  logic                     res_valid;
  logic                     res_full;
  logic                     res_match;
  logic [COUNT_WIDTH-1:0]   res_count;
  logic                     res_last;
  logic [COUNT_WIDTH+MATCH_COUNT_W-1:0] res_count_ext;

  logic                   sym_accept;
  logic                   advance;
  logic                   is_wild;
  logic [LEN_W-1:0]       len_eff;
  logic [MAX_PATTERN-1:0] span;
  logic [MAX_PATTERN-1:0] text_window_next;
  logic [MAX_PATTERN-1:0] wildcard_mask_next;
  logic [FILL_W-1:0]      fill_level_next;
  logic [NG*8-1:0]        wild_in_span;
  logic [GC_W-1:0]        group_cnt_next [NG];
  logic                   diff_zero_next;
  logic                   full_next;
  logic [LEN_W-1:0]       window_wildcards;
  logic                   match;
  logic [COUNT_WIDTH-1:0] count_inc;

  assign advance    = !res_valid || res.ready;
  assign sym.ready  = !s1_valid || advance;
  assign sym_accept = sym.valid && sym.ready;
  assign cfg.ready  = 1'b1;

  // window update and stage-1 compare
  always_comb begin
    is_wild = sym.symbol[1];
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = pattern_length;
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      span[i] = LEN_W'(i) < len_eff;
    end
    text_window_next   = (text_window << 1)
                         | MAX_PATTERN'(!is_wild && sym.symbol[0]);
    wildcard_mask_next = (wildcard_mask << 1) | MAX_PATTERN'(is_wild);
    fill_level_next    = (fill_level < MAX_FILL) ? fill_level + FILL_W'(1) : fill_level;
    full_next          = LEN_W'(fill_level_next) >= len_eff;
    diff_zero_next     = ((text_window_next ^ pattern_bits[MAX_PATTERN-1:0])
                          & ~wildcard_mask_next & span) == '0;
    wild_in_span       = (NG*8)'(wildcard_mask_next & span);
    for (int g = 0; g < NG; g++) begin
      group_cnt_next[g] = '0;
      for (int b = 0; b < 8; b++) begin
        group_cnt_next[g] = group_cnt_next[g] + GC_W'(wild_in_span[g*8+b]);
      end
    end
  end

  // stage-2 wildcard total, limit check, saturating count
  always_comb begin
    window_wildcards = '0;
    for (int g = 0; g < NG; g++) begin
      window_wildcards = window_wildcards + LEN_W'(s1_group_cnt[g]);
    end
    match     = s1_full && s1_diff_zero && (window_wildcards <= max_wildcards);
    count_inc = (match && running_count != '1) ? running_count + COUNT_WIDTH'(1)
                                               : running_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bits   <= '0;
      pattern_length <= LEN_W'(1);
      max_wildcards  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PATTERN_BITS:   pattern_bits   <= cfg.data;
        REG_PATTERN_LENGTH: pattern_length <= cfg.data[LEN_W-1:0];
        REG_MAX_WILDCARDS:  max_wildcards  <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_window   <= '0;
      wildcard_mask <= '0;
      fill_level    <= '0;
      s1_valid      <= 1'b0;
    end else if (sym_accept) begin
      s1_valid <= 1'b1;
      // drop window history after the last symbol of a string
      if (sym.last_symbol) begin
        text_window   <= '0;
        wildcard_mask <= '0;
        fill_level    <= '0;
      end else begin
        text_window   <= text_window_next;
        wildcard_mask <= wildcard_mask_next;
        fill_level    <= fill_level_next;
      end
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_accept) begin
      s1_full      <= full_next;
      s1_last      <= sym.last_symbol;
      s1_diff_zero <= diff_zero_next;
      s1_group_cnt <= group_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid     <= 1'b0;
      running_count <= '0;
    end else if (advance) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        running_count <= s1_last ? '0 : count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      res_full  <= s1_full;
      res_match <= match;
      res_count <= count_inc;
      res_last  <= s1_last;
    end
  end

  assign res_count_ext    = (COUNT_WIDTH+MATCH_COUNT_W)'(res_count);
  assign res.valid        = res_valid;
  assign res.window_full  = res_full;
  assign res.window_match = res_match;
  assign res.match_count  = res_count_ext[MATCH_COUNT_W-1:0];
  assign res.final_result = res_last;

endmodule

// ===== tb/wwmc_match_checker.sv =====
`timescale 1ns / 1ps
module wwmc_match_checker #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  wwmc_sym_if  sym,
  wwmc_res_if  res,
  wwmc_cfg_if  cfg,
  output int   errors,
  output int   pending
);
  import wwmc_pkg::*;

  localparam int WINDOW_MAX = MAX_PATTERN_DEFAULT;

  typedef struct packed {
    logic                     window_full;
    logic                     window_match;
    logic [MATCH_COUNT_W-1:0] match_count;
    logic                     final_result;
  } match_result_t;

  match_result_t expected_results[$];
  match_result_t predicted, oldest;

  // register copies
  logic [PATTERN_W-1:0] pattern;
  logic [LEN_W-1:0]     length_cfg;
  logic [LEN_W-1:0]     wild_limit;

  // per-string window state
  logic [PATTERN_W-1:0]   text_bits;
  logic [PATTERN_W-1:0]   wild_bits;
  int                     fill;
  logic [COUNT_WIDTH-1:0] hits;

  task automatic clear_string();
    text_bits = '0;
    wild_bits = '0;
    fill      = 0;
    hits      = '0;
  endtask

  task automatic predict_symbol(input logic [SYMBOL_W-1:0] s, input logic l,
                                output match_result_t r);
    int               len;
    int               nwild;
    logic [63:0]      span;
    logic             wild;
    len = (length_cfg == 0) ? 1 : (length_cfg > WINDOW_MAX) ? WINDOW_MAX : int'(length_cfg);
    span = (len == 64) ? '1 : ((64'd1 << len) - 64'd1);
    // both wildcard codes have the upper bit set
    wild = s[1];
    text_bits = {text_bits[62:0], ~wild & s[0]};
    wild_bits = {wild_bits[62:0], wild};
    if (fill < WINDOW_MAX) fill++;
    nwild = 0;
    for (int b = 0; b < 64; b++)
      if (wild_bits[b] && span[b]) nwild++;
    r.window_full  = (fill >= len);
    r.window_match = r.window_full && (nwild <= int'(wild_limit)) &&
                     (((text_bits ^ pattern) & ~wild_bits & span) == 64'd0);
    if (r.window_match && hits != '1) hits++;
    r.match_count  = MATCH_COUNT_W'(hits);
    r.final_result = l;
    if (l) clear_string();
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("%0t: %s mismatch, got %0d expected %0d", $time, field, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pattern    = '0;
      length_cfg = 7'd1;
      wild_limit = '0;
      clear_string();
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PATTERN_BITS:   pattern    = cfg.data;
          REG_PATTERN_LENGTH: length_cfg = cfg.data[LEN_W-1:0];
          REG_MAX_WILDCARDS:  wild_limit = cfg.data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (sym.valid && sym.ready) begin
        predict_symbol(sym.symbol, sym.last_symbol, predicted);
        expected_results = {expected_results, predicted};
      end
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result beat", res.match_count, 32'd0);
        end else begin
          oldest = expected_results.pop_front();
          if (res.window_full !== oldest.window_full)
            report("window_full", 32'(res.window_full), 32'(oldest.window_full));
          if (res.window_match !== oldest.window_match)
            report("window_match", 32'(res.window_match), 32'(oldest.window_match));
          if (res.match_count !== oldest.match_count)
            report("match_count", res.match_count, oldest.match_count);
          if (res.final_result !== oldest.final_result)
            report("final_result", 32'(res.final_result), 32'(oldest.final_result));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import wwmc_pkg::*;

  // counter at its default width
  localparam int CNT_W       = COUNT_WIDTH_DEFAULT;
  localparam int ITEM_TARGET = 1650;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SAT_PHASE   = 6;
  localparam int SAT_RUN     = 300;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [SYMBOL_W-1:0] SYM_ZERO     = 2'd0;
  localparam logic [SYMBOL_W-1:0] SYM_ONE      = 2'd1;
  localparam logic [SYMBOL_W-1:0] SYM_WILD     = 2'd2;
  localparam logic [SYMBOL_W-1:0] SYM_WILD_ALT = 2'd3;

  typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_BURSTY} ready_mode_t;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   errors;
  int   pending;
  int   sent = 0;
  int   burst_left = 0;
  int   phase = 0;

  // what the stimulus believes is configured, used to shape strings
  logic [PATTERN_W-1:0] pat_cfg = '0;
  int                   len_eff = 1;

  ready_mode_t rdy_mode   = RDY_ALWAYS;
  int          rdy_timer  = 0;
  int          stall_left = 0;

  wwmc_sym_if sym_if ();
  wwmc_res_if res_if ();
  wwmc_cfg_if cfg_if ();

  wildcard_window_match_counter #(
    .MAX_PATTERN(MAX_PATTERN_DEFAULT),
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sym(sym_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  wwmc_match_checker #(
    .COUNT_WIDTH(CNT_W)
  ) match_chk (
    .clk(clk),
    .rst(rst),
    .sym(sym_if),
    .res(res_if),
    .cfg(cfg_if),
    .errors(errors),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: switch between no stalls, random stalls and stall bursts
  always @(negedge clk) begin
    if (rdy_timer == 0) begin
      rdy_mode  = ready_mode_t'($urandom_range(0, 2));
      rdy_timer = $urandom_range(20, 300);
    end else begin
      rdy_timer--;
    end
    case (rdy_mode)
      RDY_ALWAYS: res_if.ready <= 1'b1;
      RDY_RANDOM: res_if.ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_left > 0) begin
          res_if.ready <= 1'b0;
          stall_left--;
        end else begin
          res_if.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
        end
      end
    endcase
  end

  function automatic int clamp_len(input logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_PATTERN_DEFAULT) return MAX_PATTERN_DEFAULT;
    return int'(v);
  endfunction

  function automatic logic [SYMBOL_W-1:0] pattern_symbol(input int pos);
    return {1'b0, pat_cfg[len_eff-1-pos]};
  endfunction

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_PATTERN_BITS:   pat_cfg = value;
      REG_PATTERN_LENGTH: len_eff = clamp_len(value[LEN_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic send_symbol(input logic [SYMBOL_W-1:0] s, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        @(negedge clk);
        sym_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    sym_if.valid       <= 1'b1;
    sym_if.symbol      <= s;
    sym_if.last_symbol <= l;
    do @(posedge clk); while (!sym_if.ready);
    burst_left--;
    sent++;
  endtask

  // hold the sender until every result is back, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    sym_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly the pattern repeated, with wildcards and flipped bits mixed in; a noisy string is all random symbols
  task automatic send_string(input int n, input bit noisy, input bit close);
    logic [SYMBOL_W-1:0] s;
    int                  r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (noisy)       s = SYMBOL_W'($urandom_range(0, 3));
      else if (r < 4)  s = SYM_WILD;
      else if (r < 8)  s = SYM_WILD_ALT;
      else if (r < 12) s = pattern_symbol(i % len_eff) ^ SYM_ONE;
      else             s = pattern_symbol(i % len_eff);
      send_symbol(s, close && (i == n - 1));
    end
  endtask

  initial begin
    int                   r;
    int                   nstr;
    logic [LEN_W-1:0]     v;
    logic [CFG_DATA_W-1:0] upper;
    bit                   close;

    rst                = 1'b1;
    sym_if.valid       = 1'b0;
    sym_if.symbol      = SYM_ZERO;
    sym_if.last_symbol = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_PATTERN_BITS;
    cfg_if.data        = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: one-symbol pattern '0', no wildcards allowed
    send_symbol(SYM_ZERO, 1'b0);
    send_symbol(SYM_ONE, 1'b0);
    send_symbol(SYM_WILD, 1'b0);
    send_symbol(SYM_ZERO, 1'b1);
    drain();

    cfg_write(REG_PATTERN_BITS, 64'b101);
    cfg_write(REG_PATTERN_LENGTH, 64'd3);
    cfg_write(REG_MAX_WILDCARDS, 64'd1);
    // text shorter than the pattern
    send_symbol(SYM_ONE, 1'b0);
    send_symbol(SYM_ZERO, 1'b1);
    // overlapping matches
    send_symbol(SYM_ONE, 1'b0);
    send_symbol(SYM_ZERO, 1'b0);
    send_symbol(SYM_ONE, 1'b0);
    send_symbol(SYM_ZERO, 1'b0);
    send_symbol(SYM_ONE, 1'b0);
    // one wildcard passes, two do not
    send_symbol(SYM_WILD, 1'b0);
    send_symbol(SYM_ZERO, 1'b0);
    send_symbol(SYM_ONE, 1'b0);
    send_symbol(SYM_WILD_ALT, 1'b0);
    send_symbol(SYM_WILD_ALT, 1'b0);
    send_symbol(SYM_ONE, 1'b1);
    drain();

    // zero length acts as one; wildcard limit above the window length
    cfg_write(REG_PATTERN_BITS, '1);
    cfg_write(REG_PATTERN_LENGTH, 64'd0);
    cfg_write(REG_MAX_WILDCARDS, 64'd127);
    send_symbol(SYM_ONE, 1'b0);
    send_symbol(SYM_ZERO, 1'b0);
    send_symbol(SYM_WILD, 1'b0);
    send_symbol(SYM_WILD_ALT, 1'b1);
    drain();

    // oversize length clamps to the maximum; the spare index changes nothing
    cfg_write(REG_PATTERN_LENGTH, {57'h1ff_ffff_ffff_ffff, 7'd100});
    cfg_write(REG_UNUSED, '1);
    send_symbol(SYM_ONE, 1'b0);
    send_symbol(SYM_WILD, 1'b0);
    send_symbol(SYM_ZERO, 1'b1);

    while (sent < ITEM_TARGET) begin
      drain();
      phase++;
      if (phase == SAT_PHASE) begin
        // every symbol a counted window: a long run of matches in one string
        cfg_write(REG_PATTERN_LENGTH, 64'd1);
        cfg_write(REG_MAX_WILDCARDS, 64'd1);
        for (int i = 0; i < SAT_RUN; i++) send_symbol(SYM_WILD, i == SAT_RUN - 1);
        drain();
      end
      if ($urandom_range(0, 3) != 0) cfg_write(REG_PATTERN_BITS, {$urandom, $urandom});
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 19);
        if (r == 0)      v = 7'd0;
        else if (r == 1) v = LEN_W'($urandom_range(65, 127));
        else if (r == 2) v = 7'd64;
        else if (r < 5)  v = LEN_W'($urandom_range(9, 63));
        else             v = LEN_W'($urandom_range(1, 8));
        upper = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : '0;
        cfg_write(REG_PATTERN_LENGTH, {upper[CFG_DATA_W-1:LEN_W], v});
      end
      if ($urandom_range(0, 2) != 0) begin
        r = $urandom_range(0, 5);
        if (r == 0)      v = 7'd0;
        else if (r == 1) v = 7'd127;
        else if (r == 2) v = 7'd64;
        else             v = LEN_W'($urandom_range(0, len_eff + 1));
        upper = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : '0;
        cfg_write(REG_MAX_WILDCARDS, {upper[CFG_DATA_W-1:LEN_W], v});
      end
      nstr = $urandom_range(1, 4);
      for (int k = 0; k < nstr; k++) begin
        // leave the final string open now and then so it spans a config change
        close = (k != nstr - 1) || ($urandom_range(0, 3) != 0);
        send_string($urandom_range(1, 3 * len_eff + 4), $urandom_range(0, 4) == 0, close);
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
